/* rtl/core/twm_pkg.sv */
// ----------------------------------------------------------------------------
// twm_pkg
// Shared constants for the time window maximum tracker: build defaults,
// register indexes, reset values, operation codes and field widths.
// ----------------------------------------------------------------------------
package twm_pkg;

    // Build defaults
    localparam int TWM_MAX_BUCKETS = 8;
    localparam int TWM_TIME_BITS   = 48;

    // Field widths
    localparam int VALUE_W  = 64;
    localparam int PERIOD_W = 32;
    localparam int COUNT_W  = 4;
    localparam int CFG_IDX_W = 1;

    // Register reset values
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 32'd1000;
    localparam logic [COUNT_W-1:0]  COUNT_RESET  = 4'd8;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 1'b1;

    // Operation codes
    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_READ   = 1'b1;

endpackage

/* rtl/core/time_window_max_tracker.sv */
// Steps: a decide state after the accept edge, then rotation (the head steps
//   once per elapsed period up to bucket_count, or a bit-serial remainder
//   division on full expiry), then the record sweep over the buckets in use
//   or the read. One beat at a time: the input stalls until a beat is done.
// Reset (synchronous, active low): ring empty through valid bits, head 0,
//   last rotation time 0, period 1000, bucket count 8; no clearing pass.
// ----------------------------------------------------------------------------
// time_window_max_tracker
// Sliding time window maximum over a ring of buckets kept in one RAM.
// ----------------------------------------------------------------------------
module time_window_max_tracker #(
    parameter int MAX_BUCKETS = twm_pkg::TWM_MAX_BUCKETS,
    parameter int TIME_BITS   = twm_pkg::TWM_TIME_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input beats
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_op,
    input  logic signed [twm_pkg::VALUE_W-1:0] i_sample_value,
    input  logic [TIME_BITS-1:0]              i_now_time,
    // result beats
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [twm_pkg::VALUE_W-1:0] o_window_max,
    // register writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [twm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [twm_pkg::PERIOD_W-1:0]      i_cfg_data
);
    import twm_pkg::*;

    // Head index and count widths. The head always stays below MAX_BUCKETS;
    // counts run up to MAX_BUCKETS itself.
    localparam int HW     = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int HW1    = HW + 1;
    localparam int CNT_W  = $clog2(MAX_BUCKETS + 1);
    localparam int CMP_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int PROD_W = CNT_W + PERIOD_W;
    localparam int WIDE_W = (TIME_BITS > PROD_W) ? TIME_BITS : PROD_W;
    localparam int DIV_W  = $clog2(TIME_BITS);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_DECIDE   = 9'b000000010,
        S_MOD      = 9'b000000100,
        S_STEP     = 9'b000001000,
        S_REC      = 9'b000010000,
        S_REC_LAST = 9'b000100000,
        S_RD       = 9'b001000000,
        S_RESP     = 9'b010000000,
        S_SPARE    = 9'b100000000
    } t_state;

    // Control state
    t_state                  r_state, n_state;
    logic [PERIOD_W-1:0]     r_period, n_period;
    logic [COUNT_W-1:0]      r_count, n_count;
    logic [HW-1:0]           r_head, n_head;
    logic [TIME_BITS-1:0]    r_last, n_last;
    logic [MAX_BUCKETS-1:0]  r_valid, n_valid;
    logic                    r_out_valid, n_out_valid;
    logic                    r_rd_pend, n_rd_pend;

    // Work registers
    logic                    r_op, n_op;
    logic [VALUE_W-1:0]      r_val, n_val;
    logic [TIME_BITS-1:0]    r_now, n_now;
    logic [TIME_BITS-1:0]    r_elapsed, n_elapsed;
    logic [PROD_W-1:0]       r_prod, n_prod;
    logic [PERIOD_W-1:0]     r_rem, n_rem;
    logic [DIV_W-1:0]        r_div_cnt, n_div_cnt;
    logic [CNT_W-1:0]        r_steps, n_steps;
    logic [CNT_W-1:0]        r_idx, n_idx;
    logic [HW-1:0]           r_rd_idx, n_rd_idx;
    logic [VALUE_W-1:0]      r_out_data, n_out_data;
    logic [VALUE_W-1:0]      r_rdata;

    // Bucket RAM
    logic [VALUE_W-1:0]      mem [MAX_BUCKETS];
    logic                    w_we, w_re;
    logic [HW-1:0]           w_waddr, w_raddr;

    // Datapath
    logic                    w_in_acc;
    logic [PERIOD_W-1:0]     w_per;
    logic [CNT_W-1:0]        w_cnt;
    logic [CMP_W-1:0]        w_bc_ext;
    logic [WIDE_W-1:0]       w_el_wide;
    logic                    w_below, w_expire, w_more;
    logic [HW1-1:0]          w_head_inc;
    logic [HW-1:0]           w_head_next;
    logic [CNT_W-1:0]        w_steps_inc;
    logic [PERIOD_W:0]       w_rem_sh;
    logic [PERIOD_W-1:0]     w_rem_next;
    logic [VALUE_W-1:0]      w_cur;
    t_state                  w_post_state;

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_out_valid  = r_out_valid;
    assign o_window_max = r_out_data;
    assign w_in_acc     = i_in_valid && !o_in_stall;

    // Effective period and bucket count: zero period acts as one, count is
    // clamped into 1..MAX_BUCKETS.
    always_comb begin
        w_per    = (r_period == '0) ? PERIOD_W'(1) : r_period;
        w_bc_ext = CMP_W'(r_count);
        if (r_count == '0) begin
            w_cnt = CNT_W'(1);
        end else if (w_bc_ext > CMP_W'(MAX_BUCKETS)) begin
            w_cnt = CNT_W'(MAX_BUCKETS);
        end else begin
            w_cnt = CNT_W'(r_count);
        end
    end

    // Rotation decision on the registered elapsed time and count * period.
    assign w_el_wide = WIDE_W'(r_elapsed);
    assign w_below   = w_el_wide < WIDE_W'(w_per);
    assign w_expire  = w_el_wide > WIDE_W'(r_prod);
    // elapsed - period > period, written without the subtract
    assign w_more    = w_el_wide > WIDE_W'({w_per, 1'b0});

    // Advance the head, wrap at the count (also when it sits beyond it).
    assign w_head_inc  = HW1'(r_head) + HW1'(1);
    assign w_head_next = (w_head_inc >= HW1'(w_cnt)) ? '0 : w_head_inc[HW-1:0];
    assign w_steps_inc = r_steps + CNT_W'(1);

    // One restoring division step per cycle, MSB of elapsed first.
    assign w_rem_sh   = {r_rem, r_elapsed[TIME_BITS-1]};
    assign w_rem_next = (w_rem_sh >= {1'b0, w_per})
                      ? PERIOD_W'(w_rem_sh - {1'b0, w_per})
                      : w_rem_sh[PERIOD_W-1:0];

    // Entry never written since the last clear reads as zero.
    assign w_cur = r_valid[r_rd_idx] ? r_rdata : '0;

    assign w_post_state = (r_op == OP_RECORD) ? S_REC : S_RD;

    always_comb begin
        n_state     = r_state;
        n_period    = r_period;
        n_count     = r_count;
        n_head      = r_head;
        n_last      = r_last;
        n_valid     = r_valid;
        n_out_valid = r_out_valid;
        n_rd_pend   = 1'b0;
        n_op        = r_op;
        n_val       = r_val;
        n_now       = r_now;
        n_elapsed   = r_elapsed;
        n_prod      = r_prod;
        n_rem       = r_rem;
        n_div_cnt   = r_div_cnt;
        n_steps     = r_steps;
        n_idx       = r_idx;
        n_rd_idx    = r_rd_idx;
        n_out_data  = r_out_data;
        w_we        = 1'b0;
        w_waddr     = r_rd_idx;
        w_re        = 1'b0;
        w_raddr     = r_head;

        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PERIOD: n_period = i_cfg_data;
                CFG_COUNT:  n_count  = i_cfg_data[COUNT_W-1:0];
                default:    n_period = r_period;
            endcase
        end

        // Drop the result beat once taken.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        // Finish a pending record compare: raise the bucket to the sample.
        if (r_rd_pend && ($signed(r_val) > $signed(w_cur))) begin
            w_we              = 1'b1;
            n_valid[r_rd_idx] = 1'b1;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_op      = i_op;
                    n_val     = i_sample_value;
                    n_now     = i_now_time;
                    n_elapsed = i_now_time - r_last;
                    n_prod    = PROD_W'(w_cnt) * PROD_W'(w_per);
                    n_state   = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_idx   = '0;
                n_steps = '0;
                if (w_below) begin
                    n_state = w_post_state;
                end else if (w_expire) begin
                    // Full expiry: empty every bucket, head back to 0.
                    n_valid   = '0;
                    n_head    = '0;
                    n_rem     = '0;
                    n_div_cnt = '0;
                    n_state   = S_MOD;
                end else begin
                    n_state = S_STEP;
                end
            end
            S_MOD: begin
                n_rem     = w_rem_next;
                n_elapsed = {r_elapsed[TIME_BITS-2:0], 1'b0};
                n_div_cnt = r_div_cnt + DIV_W'(1);
                if (r_div_cnt == DIV_W'(TIME_BITS - 1)) begin
                    // Align the rotation time down to the period.
                    n_last  = r_now - TIME_BITS'(w_rem_next);
                    n_state = w_post_state;
                end
            end
            S_STEP: begin
                n_valid[r_head] = 1'b0;
                n_head          = w_head_next;
                n_elapsed       = r_elapsed - TIME_BITS'(w_per);
                n_last          = r_last + TIME_BITS'(w_per);
                n_steps         = w_steps_inc;
                if (!(w_more && (w_steps_inc < w_cnt))) begin
                    n_state = w_post_state;
                end
            end
            S_REC: begin
                // Read bucket idx now, compare it next cycle.
                w_re      = 1'b1;
                w_raddr   = r_idx[HW-1:0];
                n_rd_pend = 1'b1;
                n_rd_idx  = r_idx[HW-1:0];
                n_idx     = r_idx + CNT_W'(1);
                if (n_idx == w_cnt) begin
                    n_state = S_REC_LAST;
                end
            end
            S_REC_LAST: begin
                n_state = S_IDLE;
            end
            S_RD: begin
                w_re     = 1'b1;
                w_raddr  = r_head;
                n_rd_idx = r_head;
                n_state  = S_RESP;
            end
            S_RESP: begin
                // Hold the read data until the output register frees up.
                if (!r_out_valid || !i_out_stall) begin
                    n_out_data  = w_cur;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_period    <= PERIOD_RESET;
            r_count     <= COUNT_RESET;
            r_head      <= '0;
            r_last      <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_rd_pend   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_period    <= n_period;
            r_count     <= n_count;
            r_head      <= n_head;
            r_last      <= n_last;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
            r_rd_pend   <= n_rd_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_val      <= n_val;
        r_now      <= n_now;
        r_elapsed  <= n_elapsed;
        r_prod     <= n_prod;
        r_rem      <= n_rem;
        r_div_cnt  <= n_div_cnt;
        r_steps    <= n_steps;
        r_idx      <= n_idx;
        r_rd_idx   <= n_rd_idx;
        r_out_data <= n_out_data;
    end

    // Bucket RAM: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= r_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_re) begin
            r_rdata <= mem[w_raddr];
        end
    end

`ifndef SYNTHESIS
    // Full expiry leaves an empty ring with the head at 0.
    a_expire_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE && !w_below && w_expire) |=>
            (r_valid == '0 && r_head == '0))
        else $error("full expiry did not clear the ring");

    // The record sweep never reads past the buckets in use.
    a_sweep_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REC) |-> (r_idx < w_cnt))
        else $error("record sweep beyond bucket count");

    // After each division step the remainder stays below the period.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOD && r_div_cnt != '0) |-> (r_rem < w_per))
        else $error("remainder not below period");
`endif

endmodule

/* dv/time_window_max_tracker_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// time_window_max_tracker testbench
// Feeds timestamped record and read beats into the window maximum tracker,
// keeps its own model of the bucket ring and checks every window_max result
// in order. Runs a directed opening and then random traffic under several
// period and bucket count settings, with random gaps, stalls and long
// receiver hold-offs.
// ----------------------------------------------------------------------------
module testbench;
    import twm_pkg::*;

    localparam int TW           = TWM_TIME_BITS;
    localparam int MAXB         = TWM_MAX_BUCKETS;
    localparam int BEATS_PER_SET = 205;
    localparam int DRAIN_CYCLES = 100;     // well past the slowest beat
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 1500000;

    localparam logic signed [VALUE_W-1:0] VAL_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [VALUE_W-1:0] VAL_MIN = 64'sh8000_0000_0000_0000;

    typedef struct packed {
        logic                      op;
        logic signed [VALUE_W-1:0] value;
        logic [TW-1:0]             stamp;
    } t_sample_beat;

    // DUT inputs, all known from time zero
    logic                       i_clk          = 1'b0;
    logic                       i_rst_n        = 1'b0;
    logic                       i_in_valid     = 1'b0;
    logic                       o_in_stall;
    logic                       i_op           = OP_RECORD;
    logic signed [VALUE_W-1:0]  i_sample_value = '0;
    logic [TW-1:0]              i_now_time     = '0;
    logic                       o_out_valid;
    logic                       i_out_stall    = 1'b0;
    logic signed [VALUE_W-1:0]  o_window_max;
    logic                       i_cfg_valid    = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_IDX_W-1:0]       i_cfg_index    = CFG_PERIOD;
    logic [PERIOD_W-1:0]        i_cfg_data     = '0;

    // Stimulus and expectation stores
    t_sample_beat               beat_q [$];
    logic signed [VALUE_W-1:0]  window_max_q [$];
    int                         beats_queued = 0;
    int                         beats_taken  = 0;   // NBA only, read across processes
    logic [TW-1:0]              cur_stamp    = '0;

    // Ring model: own copy of the buckets, head, rotation time and registers
    logic signed [VALUE_W-1:0]  ring_bucket [0:MAXB-1];
    int                         ring_head;
    logic [TW-1:0]              ring_last;
    logic [PERIOD_W-1:0]        ring_period;
    logic [COUNT_W-1:0]         ring_count;

    // Bookkeeping for the summary
    int errors       = 0;
    int n_checked    = 0;
    int n_steps      = 0;
    int n_partial    = 0;
    int n_expiry     = 0;
    int n_settings   = 0;
    int cycle_cnt    = 0;

    // Driver and receiver pacing
    int gap_left     = 0;
    int burst_left   = 0;
    int run_left     = 0;
    int stall_left   = 0;
    logic hold_on    = 1'b0;
    int hold_left    = 0;
    int holds_done   = 0;
    int pick;
    t_sample_beat next_beat;
    logic signed [VALUE_W-1:0] mon_exp;

    time_window_max_tracker u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_sample_value (i_sample_value),
        .i_now_time     (i_now_time),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_window_max   (o_window_max),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predict one accepted beat: rotate the ring to the beat's timestamp, then
    // apply the record or queue the window maximum that a read must return.
    // ------------------------------------------------------------------------
    task automatic predict_window_max(input logic op, input logic signed [VALUE_W-1:0] v,
                                      input logic [TW-1:0] now);
        longint unsigned el, per, cnt, rem;
        logic [TW-1:0]   diff;
        int              steps, i;
        diff = now - ring_last;                 // wraps modulo 2^TW
        el   = {{(64-TW){1'b0}}, diff};
        // a zero period acts as one tick; the count saturates to 1..MAXB
        per  = (ring_period == '0) ? 64'd1 : {32'd0, ring_period};
        cnt  = (ring_count == '0) ? 64'd1 :
               (ring_count > MAXB) ? 64'(MAXB) : {60'd0, ring_count};
        if (el >= per) begin
            if (el > cnt * per) begin
                // full expiry: wipe every built bucket, realign to the period
                for (i = 0; i < MAXB; i++) ring_bucket[i] = '0;
                ring_head = 0;
                rem       = el % per;
                ring_last = now - rem[TW-1:0];
                n_expiry++;
            end else begin
                // catch-up: one bucket per period, stop on an exact remainder
                steps = 0;
                do begin
                    ring_bucket[ring_head] = '0;
                    ring_head = (ring_head + 1 >= cnt) ? 0 : ring_head + 1;
                    el        = el - per;
                    ring_last = ring_last + per[TW-1:0];
                    steps++;
                end while (el > per && steps < cnt);
                n_steps += steps;
                if (el == per) n_partial++;
            end
        end
        if (op == OP_RECORD) begin
            // raise only the buckets in use; a stale head beyond them is left
            for (i = 0; i < cnt; i++)
                if (v > ring_bucket[i]) ring_bucket[i] = v;
        end else begin
            window_max_q.push_back(ring_bucket[ring_head]);
        end
    endtask

    task automatic push_beat(input logic op, input logic signed [VALUE_W-1:0] v,
                             input logic [TW-1:0] t);
        t_sample_beat b;
        b.op    = op;
        b.value = v;
        b.stamp = t;
        beat_q.push_back(b);
        beats_queued++;
        cur_stamp = t;
    endtask

    // Random traffic for one register setting. Time steps land inside a period,
    // on exact multiples, anywhere in the window, beyond it, not at all, or jump anywhere.
    task automatic queue_random_beats(input int n, input logic [PERIOD_W-1:0] period,
                                      input logic [COUNT_W-1:0] count);
        longint unsigned per, cnt, k, delta;
        logic signed [VALUE_W-1:0] v;
        logic op;
        int r, j;
        per = (period == '0) ? 64'd1 : {32'd0, period};
        cnt = (count == '0) ? 64'd1 : (count > MAXB) ? 64'(MAXB) : {60'd0, count};
        for (j = 0; j < n; j++) begin
            op = ($urandom_range(0, 99) < 40) ? OP_READ : OP_RECORD;
            r  = $urandom_range(0, 99);
            if (r < 8)       v = VAL_MAX;
            else if (r < 16) v = VAL_MIN;
            else if (r < 20) v = '0;
            else if (r < 50) v = $signed(64'($urandom_range(0, 200))) - 100;
            else             v = {$urandom, $urandom};
            r = $urandom_range(0, 99);
            k = $urandom_range(1, int'(cnt));
            if (r < 35)      delta = 64'($urandom) % per;
            else if (r < 55) delta = k * per;
            else if (r < 75) delta = (k - 1) * per + 64'($urandom) % per;
            else if (r < 88) delta = cnt * per + $urandom_range(1, 3);
            else             delta = 0;
            if (r >= 96)
                push_beat(op, v, TW'({$urandom, $urandom}));
            else
                push_beat(op, v, cur_stamp + delta[TW-1:0]);
        end
    endtask

    // Hold until every queued beat is taken and every read has answered, then
    // give a record still in flight time to retire.
    task automatic wait_drained;
        while (beats_taken != beats_queued || window_max_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PERIOD_W-1:0] d);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_PERIOD) ring_period = d;
        else                   ring_count  = d[COUNT_W-1:0];
    endtask

    // ------------------------------------------------------------------------
    // Driver: present beats from beat_q, hold a stalled beat, insert gaps.
    // The beat is predicted at the edge where it is taken.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                predict_window_max(i_op, i_sample_value, i_now_time);
                beats_taken <= beats_taken + 1;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (beat_q.size() != 0) begin
                    next_beat = beat_q.pop_front();
                    i_op           <= next_beat.op;
                    i_sample_value <= next_beat.value;
                    i_now_time     <= next_beat.stamp;
                    i_in_valid     <= 1'b1;
                    // pick the idle gap ahead of the following beat
                    pick = $urandom_range(0, 99);
                    if (burst_left > 0) begin
                        burst_left--;
                        gap_left = 0;
                    end else if (pick < 3) begin
                        burst_left = $urandom_range(30, 80);
                        gap_left   = 0;
                    end else if (pick < 70) gap_left = 0;
                    else if (pick < 95)     gap_left = $urandom_range(1, 3);
                    else                    gap_left = $urandom_range(10, 40);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check each taken result against the oldest expectation and
    // drive the result stall in alternating run and stall stretches.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (window_max_q.size() == 0) begin
                    $error("window_max: unexpected result %0d", o_window_max);
                    errors++;
                end else begin
                    mon_exp = window_max_q.pop_front();
                    n_checked++;
                    if (o_window_max !== mon_exp) begin
                        $error("window_max mismatch: expected %0d, actual %0d",
                               mon_exp, o_window_max);
                        errors++;
                    end
                end
            end
            if (stall_left > 0) stall_left--;
            else if (run_left > 0) run_left--;
            else begin
                run_left   = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300)
                                                          : $urandom_range(1, 20);
                stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                          : $urandom_range(20, 60);
            end
            i_out_stall <= hold_on || (stall_left > 0);
        end
    end

    // Long hold-off on the result side while beats keep coming, twice per run,
    // so the block backs up and stalls its input.
    always @(posedge i_clk) begin
        if (!hold_on && holds_done < 2 && beats_taken >= (holds_done + 1) * 600) begin
            hold_on   <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end else if (hold_on) begin
            if (hold_left == 0) begin
                hold_on    <= 1'b0;
                holds_done <= holds_done + 1;
            end else begin
                hold_left <= hold_left - 1;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequencer: reset, directed opening at the reset settings, then random
    // traffic per setting. Registers change only once the block has drained.
    // ------------------------------------------------------------------------
    initial begin
        logic [PERIOD_W-1:0] set_period [0:8];
        logic [COUNT_W-1:0]  set_count  [0:8];
        int p, q;
        // Counts rise and fall so a stale head beyond a new lower count
        // gets read and then wrapped.
        set_period = '{32'd1, 32'd0, 32'd7, 32'hFFFF_FFFF, 32'd1000,
                       32'd25, 32'd3, 32'd100000, 32'd2};
        set_count  = '{4'd8, 4'd1, 4'd3, 4'd8, 4'd15, 4'd0, 4'd5, 4'd9, 4'd4};
        for (q = 0; q < MAXB; q++) ring_bucket[q] = '0;
        ring_head   = 0;
        ring_last   = '0;
        ring_period = PERIOD_RESET;
        ring_count  = COUNT_RESET;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: period 1000, eight buckets, time from zero
        push_beat(OP_READ,   '0,      48'd0);       // empty ring reads zero
        push_beat(OP_RECORD, VAL_MAX, 48'd10);
        push_beat(OP_READ,   '0,      48'd20);
        push_beat(OP_RECORD, VAL_MIN, 48'd30);      // below every bucket
        push_beat(OP_READ,   VAL_MIN, 48'd999);     // just short of a period
        push_beat(OP_READ,   '0,      48'd1000);    // exactly one period
        push_beat(OP_RECORD, -64'sd5, 48'd1500);
        push_beat(OP_READ,   '0,      48'd3000);    // two periods: one left over
        push_beat(OP_READ,   '0,      48'd3000);    // leftover period steps now
        push_beat(OP_RECORD, 64'sd123, 48'd3100);
        push_beat(OP_READ,   '0,      48'd20000);   // past the window: expiry
        push_beat(OP_RECORD, -64'sd1, 48'd20000);
        push_beat(OP_READ,   '0,      48'd20000);
        push_beat(OP_RECORD, 64'sd42, 48'd20001);
        push_beat(OP_READ,   '0,      48'd28000);   // exactly the window: walk
        push_beat(OP_RECORD, 64'sh5555_AAAA_5555_AAAA, 48'd28500);
        push_beat(OP_READ,   '0,      48'hFFFF_FFFF_FFFF);
        push_beat(OP_RECORD, 64'shAAAA_5555_AAAA_5555, 48'hFFFF_FFFF_FFFF);
        push_beat(OP_READ,   '0,      48'h0000_0000_0100); // time wraps
        push_beat(OP_RECORD, 64'sd7,  48'h0000_0000_0400);
        push_beat(OP_READ,   '0,      48'h0000_0000_0900);
        wait_drained();

        for (p = 0; p < 9; p++) begin
            write_reg(CFG_PERIOD, set_period[p]);
            // stray upper data bits on a count write are dropped
            write_reg(CFG_COUNT, PERIOD_W'({$urandom, set_count[p]}));
            n_settings++;
            // open with a read at the current time to catch a stale head
            push_beat(OP_READ, '0, cur_stamp);
            queue_random_beats(BEATS_PER_SET, set_period[p], set_count[p]);
            wait_drained();
        end

        if (window_max_q.size() != 0) begin
            $error("window_max: %0d results never arrived", window_max_q.size());
            errors++;
        end
        $display("Ran %0d beats over %0d register settings, %0d reads checked.",
                 beats_taken, n_settings + 1, n_checked);
        $display("Ring model saw %0d catch-up steps, %0d left-over periods, %0d expiries.",
                 n_steps, n_partial, n_expiry);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
